// ===== design/ssfs_pkg.sv =====
`timescale 1ns / 1ps

package ssfs_pkg;

    localparam int unsigned FRAME_BITS = 21;
    localparam int unsigned CNT_W      = 5;
    localparam int unsigned RPT_W      = 4;
    localparam int unsigned GAP_W      = 16;
    localparam int unsigned CHAR_W     = 7;

    localparam logic [CNT_W-1:0] LAST_BIT_POS = CNT_W'(FRAME_BITS - 1);
    localparam logic [CNT_W-1:0] FRAME_LEN    = CNT_W'(FRAME_BITS);
    localparam logic [RPT_W-1:0] RPT_MAX      = '1;

    localparam logic [GAP_W-1:0] GAP_LIMIT_RST = 16'd1000;
    localparam logic [RPT_W-1:0] REPEATS_RST   = 4'd3;

    // Register map, indexed by paddr[2]
    localparam logic REG_GAP_LIMIT = 1'b0;
    localparam logic REG_REPEATS   = 1'b1;

    localparam logic [CHAR_W-1:0] CH_ONE     = 7'h31;
    localparam logic [CHAR_W-1:0] CH_SPACE   = 7'h20;
    localparam logic [CHAR_W-1:0] CH_UNKNOWN = 7'h3F;

    typedef logic [FRAME_BITS-1:0] t_frame;

    typedef struct packed {
        logic   publish;
        t_frame frame;
    } t_frame_evt;

    typedef struct packed {
        logic              heating;
        logic [CHAR_W-1:0] first_char;
        logic [CHAR_W-1:0] middle_char;
        logic [CHAR_W-1:0] last_char;
    } t_chars;

    // Segment pattern abcdefg ordering as on the link (bit 6 = segment a)
    function automatic logic [CHAR_W-1:0] seg_to_ascii(input logic [6:0] seg);
        logic [CHAR_W-1:0] ch;
        case (seg)
            7'h7E:   ch = 7'h30; // 0
            7'h30:   ch = 7'h31; // 1
            7'h6D:   ch = 7'h32; // 2
            7'h79:   ch = 7'h33; // 3
            7'h33:   ch = 7'h34; // 4
            7'h5B:   ch = 7'h35; // 5
            7'h5F:   ch = 7'h36; // 6
            7'h70:   ch = 7'h37; // 7
            7'h7F:   ch = 7'h38; // 8
            7'h7B:   ch = 7'h39; // 9
            7'h77:   ch = 7'h41; // A
            7'h1F:   ch = 7'h62; // b
            7'h4E:   ch = 7'h43; // C
            7'h3D:   ch = 7'h64; // d
            7'h4F:   ch = 7'h45; // E
            7'h47:   ch = 7'h46; // F
            7'h5E:   ch = 7'h47; // G
            7'h37:   ch = 7'h48; // H
            7'h06:   ch = 7'h49; // I
            7'h3C:   ch = 7'h4A; // J
            7'h3B:   ch = 7'h4B; // K
            7'h0E:   ch = 7'h4C; // L
            7'h15:   ch = 7'h6E; // n
            7'h1D:   ch = 7'h6F; // o
            7'h67:   ch = 7'h50; // P
            7'h73:   ch = 7'h71; // q
            7'h05:   ch = 7'h72; // r
            7'h0F:   ch = 7'h74; // t
            7'h3E:   ch = 7'h55; // U
            7'h3F:   ch = 7'h59; // Y
            7'h00:   ch = CH_SPACE;
            default: ch = CH_UNKNOWN;
        endcase
        return ch;
    endfunction

endpackage

// ===== design/ssfs_char_decode.sv =====
`timescale 1ns / 1ps

module ssfs_char_decode (
    input  ssfs_pkg::t_frame i_frame,
    output ssfs_pkg::t_chars o_chars
);

    always_comb begin
        o_chars.heating     = i_frame[16];
        o_chars.first_char  = (i_frame[19:18] != 2'b00) ? ssfs_pkg::CH_ONE
                                                         : ssfs_pkg::CH_SPACE;
        o_chars.middle_char = ssfs_pkg::seg_to_ascii(i_frame[13:7]);
        o_chars.last_char   = ssfs_pkg::seg_to_ascii(i_frame[6:0]);
    end

endmodule

// ===== design/ssfs_frame.sv =====
`timescale 1ns / 1ps

module ssfs_frame (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  logic [ssfs_pkg::GAP_W-1:0]     i_gap_us,
    input  logic                           i_data_bit,
    input  logic [ssfs_pkg::GAP_W-1:0]     i_gap_limit_us,
    input  logic [ssfs_pkg::RPT_W-1:0]     i_repeats_needed,
    output ssfs_pkg::t_frame_evt           o_evt
);

    logic [ssfs_pkg::CNT_W-1:0] r_bit_count, n_bit_count;
    ssfs_pkg::t_frame           r_shift_frame, n_shift_frame;
    ssfs_pkg::t_frame           r_last_frame, n_last_frame;
    logic [ssfs_pkg::RPT_W-1:0] r_repeat_count, n_repeat_count;

    logic                       restart;
    logic [ssfs_pkg::CNT_W-1:0] base_cnt;
    logic [ssfs_pkg::CNT_W-1:0] bit_pos;
    logic [ssfs_pkg::CNT_W-1:0] cnt_inc;
    ssfs_pkg::t_frame           asm_frame;
    logic [ssfs_pkg::RPT_W-1:0] rpt_inc;

    always_comb begin
        restart   = (i_gap_us > i_gap_limit_us) || (r_bit_count >= ssfs_pkg::FRAME_LEN);
        base_cnt  = restart ? '0 : r_bit_count;
        bit_pos   = ssfs_pkg::LAST_BIT_POS - base_cnt;
        // MSB first; bits of a previous frame stay unless a long gap cleared them
        asm_frame = (restart ? '0 : r_shift_frame)
                  | (ssfs_pkg::t_frame'(i_data_bit) << bit_pos);
        cnt_inc   = base_cnt + 1'b1;
        rpt_inc   = (r_repeat_count == ssfs_pkg::RPT_MAX) ? r_repeat_count
                                                          : r_repeat_count + 1'b1;

        n_bit_count    = r_bit_count;
        n_shift_frame  = r_shift_frame;
        n_last_frame   = r_last_frame;
        n_repeat_count = r_repeat_count;
        o_evt.publish  = 1'b0;
        o_evt.frame    = asm_frame;

        if (i_valid) begin
            n_shift_frame = asm_frame;
            n_bit_count   = cnt_inc;
            if (cnt_inc == ssfs_pkg::FRAME_LEN) begin
                n_bit_count = '0;
                if (asm_frame != r_last_frame) begin
                    n_last_frame   = asm_frame;
                    n_repeat_count = '0;
                end else if (rpt_inc >= i_repeats_needed) begin
                    n_repeat_count = '0;
                    o_evt.publish  = 1'b1;
                end else begin
                    n_repeat_count = rpt_inc;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_count    <= '0;
            r_shift_frame  <= '0;
            r_last_frame   <= '0;
            r_repeat_count <= '0;
        end else begin
            r_bit_count    <= n_bit_count;
            r_shift_frame  <= n_shift_frame;
            r_last_frame   <= n_last_frame;
            r_repeat_count <= n_repeat_count;
        end
    end

    a_bit_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit_count <= ssfs_pkg::LAST_BIT_POS)
        else $error("bit count ran past the frame length");

    a_publish_matches_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_evt.publish |-> (o_evt.frame == r_last_frame))
        else $error("published frame differs from the stored frame");

    a_publish_clears_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_evt.publish |=> (r_repeat_count == '0) && (r_bit_count == '0))
        else $error("repeat or bit count not cleared after publication");

endmodule

// ===== design/seven_segment_frame_sniffer_core.sv =====
`timescale 1ns / 1ps

// Seven-segment display link sniffer.
// Slave stream: one transaction per rising edge of the display link clock,
// carrying the time since the previous edge and the sampled data level.
// Edges separated by more than gap_limit_us restart the 21-bit frame; bits
// are shifted in MSB first. A complete frame seen repeats_needed more times
// in a row is published once on the master stream, with the heater bit, the
// leading-one character, two decoded digit characters and the raw frame.
// An accepted transaction is held in the input register; its result, if
// any, is then held in the result register and valid on the master side.
// Throughput: one transaction per cycle unless the result register stalls;
// the frame and repeat update from the input register is combinational.
// Stall: the result register holds until taken; while a result waits the
// input register still takes one transaction, then o_s_tready drops until
// the receiver takes the result.
// Reset (synchronous, active low) clears the frame state and repeat count
// and returns gap_limit_us to 1000 and repeats_needed to 3.
// APB: gap_limit_us at 0x0, repeats_needed at 0x4; pready is always high.

module seven_segment_frame_sniffer_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Slave stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,  // [15:0] gap_us, [16] data_bit, [23:17] zero
    // Master stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [0] heating, [7:1] first_char, [14:8] middle_char, [21:15] last_char,
    // [42:22] raw_frame, [47:43] zero
    output logic [47:0] o_m_tdata,
    // Configuration
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output logic [31:0] o_prdata,
    output logic        o_pready
);

    // Configuration registers
    logic [ssfs_pkg::GAP_W-1:0] r_gap_limit_us;
    logic [ssfs_pkg::RPT_W-1:0] r_repeats_needed;
    logic                       cfg_wr;
    logic                       reg_sel;

    assign o_pready = 1'b1;
    assign reg_sel  = i_paddr[2];
    assign cfg_wr   = i_psel && i_penable && i_pwrite && o_pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap_limit_us   <= ssfs_pkg::GAP_LIMIT_RST;
            r_repeats_needed <= ssfs_pkg::REPEATS_RST;
        end else if (cfg_wr) begin
            case (reg_sel)
                ssfs_pkg::REG_GAP_LIMIT: r_gap_limit_us   <= i_pwdata[ssfs_pkg::GAP_W-1:0];
                ssfs_pkg::REG_REPEATS:   r_repeats_needed <= i_pwdata[ssfs_pkg::RPT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            ssfs_pkg::REG_GAP_LIMIT: o_prdata = 32'(r_gap_limit_us);
            ssfs_pkg::REG_REPEATS:   o_prdata = 32'(r_repeats_needed);
            default:                 o_prdata = '0;
        endcase
    end

    // Input register
    logic                       r_in_valid;
    logic [ssfs_pkg::GAP_W-1:0] r_in_gap_us;
    logic                       r_in_data_bit;
    logic                       r_out_valid;
    logic                       advance;
    logic                       in_take;

    // Advance the pipeline whenever the result register can take a new value
    assign advance    = !r_out_valid || i_m_tready;
    assign o_s_tready = !r_in_valid || advance;
    assign in_take    = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_gap_us   <= i_s_tdata[15:0];
            r_in_data_bit <= i_s_tdata[16];
        end
    end

    // Frame assembly and repeat detection
    ssfs_pkg::t_frame_evt evt;
    ssfs_pkg::t_chars     chars;

    ssfs_frame u_frame (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (r_in_valid && advance),
        .i_gap_us         (r_in_gap_us),
        .i_data_bit       (r_in_data_bit),
        .i_gap_limit_us   (r_gap_limit_us),
        .i_repeats_needed (r_repeats_needed),
        .o_evt            (evt)
    );

    ssfs_char_decode u_decode (
        .i_frame (evt.frame),
        .o_chars (chars)
    );

    // Result register
    ssfs_pkg::t_chars    r_out_chars;
    ssfs_pkg::t_frame    r_out_frame;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= evt.publish;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && evt.publish) begin
            r_out_chars <= chars;
            r_out_frame <= evt.frame;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {5'b0, r_out_frame, r_out_chars.last_char,
                         r_out_chars.middle_char, r_out_chars.first_char,
                         r_out_chars.heating};

    a_stall_only_on_blocked_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (r_out_valid && !i_m_tready))
        else $error("input stalled without a blocked result");

    a_heating_matches_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[0] == o_m_tdata[38]))
        else $error("heating bit disagrees with raw frame");

    a_first_char_matches_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> ((o_m_tdata[7:1] == ssfs_pkg::CH_ONE) == (o_m_tdata[41:40] != 2'b00)))
        else $error("leading character disagrees with raw frame");

endmodule
